// ===== sv/rgbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbf_pkg: shared definitions for the RGB soft-PWM breathing fader
// Command codes, register indexes, reset tables of the channel bounds.
// ----------------------------------------------------------------------------
package rgbf_pkg;

   localparam int LED_COUNT_DEFAULT = 3;
   localparam int LED_COUNT_MAX     = 8;
   localparam int CH_MAX            = 3 * LED_COUNT_MAX;
   localparam int LINE_W            = 9;

   localparam logic CMD_TICK      = 1'b0;
   localparam logic CMD_SET_COLOR = 1'b1;

   localparam logic [1:0] REG_PWM_TOP        = 2'd0;
   localparam logic [1:0] REG_FADE_INNER_TOP = 2'd1;
   localparam logic [1:0] REG_FADE_OUTER_TOP = 2'd2;

   localparam logic [10:0] PWM_TOP_RESET        = 11'd1024;
   localparam logic [15:0] FADE_INNER_TOP_RESET = 16'd2500;
   localparam logic [7:0]  FADE_OUTER_TOP_RESET = 8'd250;

   // Channel order: 3*led + colour, colour 0 red, 1 green, 2 blue
   localparam logic [7:0] RESET_MIN [CH_MAX] = '{
      8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd2, 8'd0, 8'd1, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
   localparam logic [7:0] RESET_MAX [CH_MAX] = '{
      8'd2, 8'd0, 8'd2, 8'd0, 8'd1, 8'd2, 8'd1, 8'd1, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

   localparam int STEP_TWO_CHANNEL = 5;   // blue of LED1 starts at +2

endpackage

// ===== sv/rgb_soft_pwm_breathing_fader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_soft_pwm_breathing_fader_unit: soft-PWM driver with triangle fade
// Drives three lines per LED from a shared phase counter; a two-stage
// prescaler paces a bouncing fade of each channel between its bounds.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  req       in         req_valid / req_stall     command, led_index, r/g/b level
//  rsp       out        rsp_valid / rsp_stall     led_lines
//  csr       in/out     psel, penable, pready     paddr[3:0], pwdata, prdata
//
//  One transaction per clock: a request is taken whenever the result register
//  is empty or is being drained, and its result appears in the cycle after it is taken.
//  The result register is fed by a single pass of compare and add logic from
//  the channel registers.
//  Reset (synchronous, active high) restores registers, counters and the
//  channel bound tables; result register empties.
//  A stalled result holds its value; requests stall while it is held.
//
module rgb_soft_pwm_breathing_fader_unit
   import rgbf_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [2:0]  req_led_index,
   input  logic [7:0]  req_red_level,
   input  logic [7:0]  req_green_level,
   input  logic [7:0]  req_blue_level,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_led_lines,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CH_COUNT = 3 * LED_COUNT;

   // configuration registers
   logic [10:0] pwm_top_ff;
   logic [15:0] inner_top_ff;
   logic [7:0]  outer_top_ff;

   // counters and channel state
   logic [10:0] phase_ff,  phase_in;
   logic [15:0] inner_ff,  inner_in;
   logic [7:0]  outer_ff,  outer_in;
   logic [CH_COUNT-1:0] line_ff, line_in;
   logic [7:0] level_ff [CH_COUNT];
   logic [7:0] level_in [CH_COUNT];
   logic [7:0] min_ff   [CH_COUNT];
   logic [7:0] min_in   [CH_COUNT];
   logic [7:0] max_ff   [CH_COUNT];
   logic [7:0] max_in   [CH_COUNT];
   logic [7:0] step_ff  [CH_COUNT];
   logic [7:0] step_in  [CH_COUNT];

   // result register
   logic       rsp_valid_ff;
   logic [8:0] rsp_lines_ff, rsp_lines_in;

   logic        accept;
   logic        csr_write;
   logic        led_ok;
   logic [16:0] inner_inc;
   logic [8:0]  outer_inc;
   logic [11:0] phase_inc;
   logic        advance;
   logic        fade;
   logic [CH_COUNT-1:0] line_tick;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_lines = rsp_lines_ff;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      case (paddr[3:2])
         REG_PWM_TOP:        prdata = {21'd0, pwm_top_ff};
         REG_FADE_INNER_TOP: prdata = {16'd0, inner_top_ff};
         REG_FADE_OUTER_TOP: prdata = {24'd0, outer_top_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_top_ff   <= PWM_TOP_RESET;
         inner_top_ff <= FADE_INNER_TOP_RESET;
         outer_top_ff <= FADE_OUTER_TOP_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_PWM_TOP:        pwm_top_ff   <= pwdata[10:0];
            REG_FADE_INNER_TOP: inner_top_ff <= pwdata[15:0];
            REG_FADE_OUTER_TOP: outer_top_ff <= pwdata[7:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // prescaler chain and phase; compares one bit wider than each counter
   assign inner_inc = {1'b0, inner_ff} + 17'd1;
   assign advance   = inner_inc > {1'b0, inner_top_ff};
   assign outer_inc = {1'b0, outer_ff} + {8'd0, advance};
   assign fade      = outer_inc > {1'b0, outer_top_ff};
   assign phase_inc = {1'b0, phase_ff} + 12'd1;

   assign led_ok = {1'b0, req_led_index} < 4'(LED_COUNT);

   always_comb begin
      logic [7:0] lvl;
      logic [7:0] colour;
      lvl      = '0;
      colour   = '0;
      phase_in = phase_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      line_in  = line_ff;
      for (int c = 0; c < CH_COUNT; c++) begin
         level_in[c] = level_ff[c];
         min_in[c]   = min_ff[c];
         max_in[c]   = max_ff[c];
         step_in[c]  = step_ff[c];
      end

      // switch on at phase zero, then off on a level match
      for (int c = 0; c < CH_COUNT; c++) begin
         line_tick[c] = line_ff[c];
         if ((phase_ff == 11'd0) && (level_ff[c] != 8'd0)) begin
            line_tick[c] = 1'b1;
         end
         if (phase_ff == {3'd0, level_ff[c]}) begin
            line_tick[c] = 1'b0;
         end
      end

      if (req_command == CMD_TICK) begin
         line_in  = line_tick;
         inner_in = advance ? 16'd0 : inner_inc[15:0];
         outer_in = fade ? 8'd0 : outer_inc[7:0];
         phase_in = (phase_inc > {1'b0, pwm_top_ff}) ? 11'd0 : phase_inc[10:0];
         if (fade) begin
            for (int c = 0; c < CH_COUNT; c++) begin
               lvl = level_ff[c];
               if (max_ff[c] != min_ff[c]) begin
                  lvl = level_ff[c] + step_ff[c];
               end
               level_in[c] = lvl;
               // bounce at either bound
               if ((lvl <= min_ff[c]) || (lvl >= max_ff[c])) begin
                  step_in[c] = 8'd0 - step_ff[c];
               end
            end
         end
      end else if (led_ok) begin
         for (int c = 0; c < CH_COUNT; c++) begin
            case (c % 3)
               0:       colour = req_red_level;
               1:       colour = req_green_level;
               default: colour = req_blue_level;
            endcase
            if (3'(c / 3) == req_led_index) begin
               level_in[c] = colour;
               min_in[c]   = colour;
               max_in[c]   = colour;
            end
         end
      end
   end

   // map channels onto the nine output lines; missing lines read off
   always_comb begin
      rsp_lines_in = '0;
      for (int b = 0; b < LINE_W; b++) begin
         if (b < CH_COUNT) begin
            rsp_lines_in[b] = line_in[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         inner_ff <= '0;
         outer_ff <= '0;
         line_ff  <= '0;
         for (int c = 0; c < CH_COUNT; c++) begin
            level_ff[c] <= RESET_MIN[c];
            min_ff[c]   <= RESET_MIN[c];
            max_ff[c]   <= RESET_MAX[c];
            step_ff[c]  <= (c == STEP_TWO_CHANNEL) ? 8'd2 : 8'd1;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         inner_ff <= inner_in;
         outer_ff <= outer_in;
         line_ff  <= line_in;
         for (int c = 0; c < CH_COUNT; c++) begin
            level_ff[c] <= level_in[c];
            min_ff[c]   <= min_in[c];
            max_ff[c]   <= max_in[c];
            step_ff[c]  <= step_in[c];
         end
      end
   end

   // result register: load on accept, empty once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_lines_ff <= rsp_lines_in;
      end
   end

endmodule
